// ===== hdl/srs_pkg.sv =====
// Shared types, register map and constants for the sweep radar sequencer.
`default_nettype none

package srs_pkg;

  // Largest angle the servo may ever be commanded to, in degrees.
  localparam logic [7:0] ANGLE_LIMIT = 8'd180;

  // First byte of every report frame.
  localparam logic [7:0] FRAME_HEAD = 8'hAA;

  // Number of words in a report frame.
  localparam logic [2:0] FRAME_LEN = 3'd5;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_ANGLE_MAX    = 3'd0;
  localparam logic [2:0] REG_ANGLE_STEP   = 3'd1;
  localparam logic [2:0] REG_SETTLE_TICKS = 3'd2;
  localparam logic [2:0] REG_GAP_TICKS    = 3'd3;
  localparam logic [2:0] REG_RANGE_MAX_CM = 3'd4;

  // Register reset values.
  localparam logic [7:0] ANGLE_MAX_RST    = 8'd180;
  localparam logic [6:0] ANGLE_STEP_RST   = 7'd1;
  localparam logic [7:0] SETTLE_TICKS_RST = 8'd5;
  localparam logic [7:0] GAP_TICKS_RST    = 8'd1;
  localparam logic [7:0] RANGE_MAX_RST    = 8'd50;

  // Input word selector.
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_RESULT = 1'b1;

  typedef enum logic [1:0] {
    PH_MOVE,
    PH_SETTLE,
    PH_AWAIT
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SERVO,
    KIND_MEASURE,
    KIND_FRAME
  } kind_t;

  typedef struct packed {
    logic [7:0] angle_max;
    logic [6:0] angle_step;
    logic [7:0] settle_ticks;
    logic [7:0] gap_ticks;
    logic [7:0] range_max_cm;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic        echo_valid;
    logic [15:0] distance_q4;
  } item_t;

  // Results produced by one input word: none, one command, or a whole frame.
  typedef struct packed {
    logic [2:0]      count;
    kind_t           kind;
    logic [7:0]      servo_angle;
    logic [4:0][7:0] bytes;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/srs_seq.sv =====
// Sequencer state and per-word result logic of the sweep radar sequencer.
`default_nettype none

module srs_seq (
  input  wire            clk,
  input  wire            rst,
  input  wire            step,
  input  srs_pkg::item_t item,
  input  srs_pkg::cfg_t  cfg,
  output srs_pkg::res_t  res
);

  srs_pkg::phase_t phase, phase_next;
  logic [7:0]      angle, angle_next;
  logic            going_down, going_down_next;
  logic [7:0]      countdown, countdown_next;

  logic [7:0]  lim;
  logic [8:0]  angle_up;
  logic        status;
  logic [16:0] rounded;
  logic [7:0]  dbyte;
  logic [7:0]  sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= srs_pkg::PH_MOVE;
      angle      <= 8'd0;
      going_down <= 1'b0;
      countdown  <= 8'd0;
    end else if (step) begin
      phase      <= phase_next;
      angle      <= angle_next;
      going_down <= going_down_next;
      countdown  <= countdown_next;
    end
  end

  // Classification and the frame bytes.
  always_comb begin
    lim      = (cfg.angle_max < srs_pkg::ANGLE_LIMIT) ? cfg.angle_max : srs_pkg::ANGLE_LIMIT;
    angle_up = {1'b0, angle} + {2'b00, cfg.angle_step};
    status   = item.echo_valid &&
               (item.distance_q4 <= {4'b0000, cfg.range_max_cm, 4'b0000});
    rounded  = {1'b0, item.distance_q4} + 17'd8;
    if (!status) begin
      dbyte = 8'hFF;
    end else if (rounded[16:4] > 13'd255) begin
      dbyte = 8'hFF;
    end else begin
      dbyte = rounded[11:4];
    end
    sum = srs_pkg::FRAME_HEAD + angle + {7'd0, status} + dbyte;
  end

  always_comb begin
    phase_next      = phase;
    angle_next      = angle;
    going_down_next = going_down;
    countdown_next  = countdown;
    res.count       = 3'd0;
    res.kind        = srs_pkg::KIND_SERVO;
    res.servo_angle = 8'd0;
    res.bytes       = '0;

    if (item.op == srs_pkg::OP_TICK) begin
      if (phase != srs_pkg::PH_AWAIT) begin
        if (countdown > 8'd1) begin
          countdown_next = countdown - 8'd1;
        end else begin
          countdown_next = 8'd0;
          res.count      = 3'd1;
          case (phase)
            srs_pkg::PH_MOVE: begin
              res.kind        = srs_pkg::KIND_SERVO;
              res.servo_angle = angle;
              phase_next      = srs_pkg::PH_SETTLE;
              countdown_next  = cfg.settle_ticks;
            end
            default: begin
              res.kind   = srs_pkg::KIND_MEASURE;
              phase_next = srs_pkg::PH_AWAIT;
            end
          endcase
        end
      end
    end else if (phase == srs_pkg::PH_AWAIT) begin
      res.count    = srs_pkg::FRAME_LEN;
      res.kind     = srs_pkg::KIND_FRAME;
      res.bytes[0] = srs_pkg::FRAME_HEAD;
      res.bytes[1] = angle;
      res.bytes[2] = {7'd0, status};
      res.bytes[3] = dbyte;
      res.bytes[4] = sum;
      phase_next     = srs_pkg::PH_MOVE;
      countdown_next = cfg.gap_ticks;
      // Ping-pong the angle between zero and the sweep limit.
      if (!going_down) begin
        if (angle_up >= {1'b0, lim}) begin
          angle_next      = lim;
          going_down_next = 1'b1;
        end else begin
          angle_next = angle_up[7:0];
        end
      end else if (angle <= {1'b0, cfg.angle_step}) begin
        angle_next      = 8'd0;
        going_down_next = 1'b0;
      end else begin
        angle_next = angle - {1'b0, cfg.angle_step};
      end
    end
  end

  // The wait for a result is only entered from an expired countdown.
  a_await_count_zero: assert property (@(posedge clk) disable iff (rst)
    phase == srs_pkg::PH_AWAIT |-> countdown == 8'd0)
    else $error("countdown running while awaiting a result");

  a_frame_to_move: assert property (@(posedge clk) disable iff (rst)
    step && res.count == srs_pkg::FRAME_LEN |=> phase == srs_pkg::PH_MOVE)
    else $error("frame did not return the sequencer to the move phase");

  a_await_tick_hold: assert property (@(posedge clk) disable iff (rst)
    step && item.op == srs_pkg::OP_TICK && phase == srs_pkg::PH_AWAIT
    |=> phase == srs_pkg::PH_AWAIT && $stable(angle))
    else $error("tick disturbed the sequencer while awaiting a result");

endmodule

`default_nettype wire

// ===== hdl/sweep_radar_sequencer_unit.sv =====
// Top level of the sweep radar sequencer: register port, input stage and result stage.
`default_nettype none

// Channel   Direction  Handshake            Contents
// s_*       in         s_tvalid / s_tready  tick or measurement result word
// m_*       out        m_tvalid / m_tready  servo command, measure request or frame byte
// apb       in/out     psel, penable        five configuration registers at 4*index
//
// An accepted word is held in the input register, then passes through the combinational
// sequencer logic into the result register.
// Ticks give at most one output word, so they sustain one word per cycle while m_tready
// is high; a measurement result fills the result register with a five-word frame, which
// then drains one word per cycle while m_tready is high.
// The input register accepts the next word while the result register still drains,
// and a stall on m_tready backs up into s_tready only once the input register is full.
// Reset is synchronous and active high; it restores the register defaults, puts the
// sequencer in the move phase at angle zero sweeping upward, and empties both stages.

module sweep_radar_sequencer_unit (
  input  wire         clk,
  input  wire         rst,
  // APB configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // [15:0] distance_q4
  input  wire  [1:0]  s_tuser,   // [0] op, [1] echo_valid
  // Output stream
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,   // [7:0] servo_angle, [15:8] frame_byte
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);

  srs_pkg::cfg_t  cfg;
  srs_pkg::item_t in_item;
  srs_pkg::res_t  res;
  srs_pkg::res_t  res_buf;

  logic       in_valid;
  logic       in_taken;
  logic [2:0] rem;
  logic [2:0] pos;
  logic       cfg_wr;

  // Configuration registers. The user must write only while the block is idle; the block does not enforce it.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_max    <= srs_pkg::ANGLE_MAX_RST;
      cfg.angle_step   <= srs_pkg::ANGLE_STEP_RST;
      cfg.settle_ticks <= srs_pkg::SETTLE_TICKS_RST;
      cfg.gap_ticks    <= srs_pkg::GAP_TICKS_RST;
      cfg.range_max_cm <= srs_pkg::RANGE_MAX_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        srs_pkg::REG_ANGLE_MAX:    cfg.angle_max    <= pwdata[7:0];
        srs_pkg::REG_ANGLE_STEP:   cfg.angle_step   <= pwdata[6:0];
        srs_pkg::REG_SETTLE_TICKS: cfg.settle_ticks <= pwdata[7:0];
        srs_pkg::REG_GAP_TICKS:    cfg.gap_ticks    <= pwdata[7:0];
        srs_pkg::REG_RANGE_MAX_CM: cfg.range_max_cm <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      srs_pkg::REG_ANGLE_MAX:    prdata = {24'd0, cfg.angle_max};
      srs_pkg::REG_ANGLE_STEP:   prdata = {25'd0, cfg.angle_step};
      srs_pkg::REG_SETTLE_TICKS: prdata = {24'd0, cfg.settle_ticks};
      srs_pkg::REG_GAP_TICKS:    prdata = {24'd0, cfg.gap_ticks};
      srs_pkg::REG_RANGE_MAX_CM: prdata = {24'd0, cfg.range_max_cm};
      default:                   prdata = 32'd0;
    endcase
  end

  // The held word moves on when the result register is empty or is handing
  // over its final word in this cycle.
  assign in_taken = in_valid && ((rem == 3'd0) || (rem == 3'd1 && m_tready));
  assign s_tready = !in_valid || in_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (in_taken) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.op          <= s_tuser[0];
      in_item.echo_valid  <= s_tuser[1];
      in_item.distance_q4 <= s_tdata;
    end
  end

  srs_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (in_taken),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register: rem counts the words still to go, pos picks the frame byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
      pos <= 3'd0;
    end else if (in_taken) begin
      rem <= res.count;
      pos <= 3'd0;
    end else if (m_tvalid && m_tready) begin
      rem <= rem - 3'd1;
      pos <= pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_taken) begin
      res_buf <= res;
    end
  end

  assign m_tvalid = (rem != 3'd0);
  assign m_tlast  = (rem == 3'd1);
  assign m_tuser  = res_buf.kind;
  assign m_tdata  = {res_buf.bytes[pos], res_buf.servo_angle};

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    rem == 3'd0 |-> s_tready)
    else $error("input stalled while the result register is empty");

  a_frame_continues: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == $past(m_tuser))
    else $error("frame broken off before its last word");

  a_frame_load: assert property (@(posedge clk) disable iff (rst)
    in_taken && res.count == srs_pkg::FRAME_LEN
    |=> rem == srs_pkg::FRAME_LEN && pos == 3'd0)
    else $error("frame not loaded whole into the result register");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the sweep radar sequencer: stream and register stimulus.
`timescale 1ns / 1ps

module tb;
  import srs_pkg::*;

  // Register indexes past the end of the map; writes to them must have no effect.
  localparam logic [2:0] REG_SPARE     = 3'd5;
  localparam logic [2:0] REG_SPARE_TOP = 3'd7;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] servo_angle;
    logic [7:0] frame_byte;
    logic       is_last;
  } out_word_t;

  // Mirrors the sequencer state and queues the words each accepted input word should
  // produce, then matches the output stream against that queue in order.
  class sweep_tracker;
    cfg_t        cfg;
    phase_t      phase;
    logic [7:0]  angle;
    logic        going_down;
    logic [7:0]  countdown;
    out_word_t   due_words[$];
    int          faults;
    int          inputs;
    int          ignored;
    int          words_seen;
    int          servo_count;
    int          measure_count;
    int          frame_count;

    function new();
      cfg.angle_max    = ANGLE_MAX_RST;
      cfg.angle_step   = ANGLE_STEP_RST;
      cfg.settle_ticks = SETTLE_TICKS_RST;
      cfg.gap_ticks    = GAP_TICKS_RST;
      cfg.range_max_cm = RANGE_MAX_RST;
      phase      = PH_MOVE;
      angle      = 8'd0;
      going_down = 1'b0;
      countdown  = 8'd0;
    endfunction

    function void fault(string msg);
      faults++;
      if (faults <= 10) $display("MISMATCH %0t: %s", $realtime, msg);
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_ANGLE_MAX:    cfg.angle_max    = val[7:0];
        REG_ANGLE_STEP:   cfg.angle_step   = val[6:0];
        REG_SETTLE_TICKS: cfg.settle_ticks = val[7:0];
        REG_GAP_TICKS:    cfg.gap_ticks    = val[7:0];
        REG_RANGE_MAX_CM: cfg.range_max_cm = val[7:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [2:0] idx);
      case (idx)
        REG_ANGLE_MAX:    return {24'd0, cfg.angle_max};
        REG_ANGLE_STEP:   return {25'd0, cfg.angle_step};
        REG_SETTLE_TICKS: return {24'd0, cfg.settle_ticks};
        REG_GAP_TICKS:    return {24'd0, cfg.gap_ticks};
        REG_RANGE_MAX_CM: return {24'd0, cfg.range_max_cm};
        default:          return 32'd0;
      endcase
    endfunction

    function void push_word(logic [1:0] kind, logic [7:0] sa, logic [7:0] fb, logic is_last);
      out_word_t w;
      w.kind        = kind;
      w.servo_angle = sa;
      w.frame_byte  = fb;
      w.is_last     = is_last;
      due_words.push_back(w);
    endfunction

    // The sweep bounces between zero and the smaller of angle_max and the hard limit.
    function void step_angle();
      logic [7:0] lim;
      logic [8:0] next_angle;
      lim = (cfg.angle_max < ANGLE_LIMIT) ? cfg.angle_max : ANGLE_LIMIT;
      if (!going_down) begin
        next_angle = {1'b0, angle} + {2'b00, cfg.angle_step};
        if (next_angle >= {1'b0, lim}) begin
          angle      = lim;
          going_down = 1'b1;
        end else begin
          angle = next_angle[7:0];
        end
      end else begin
        if (angle <= {1'b0, cfg.angle_step}) begin
          angle      = 8'd0;
          going_down = 1'b0;
        end else begin
          angle = angle - {1'b0, cfg.angle_step};
        end
      end
    endfunction

    function void take_input(logic op, logic echo, logic [15:0] dist_q4);
      logic            status;
      logic [16:0]     rounded;
      logic [7:0]      dbyte;
      logic [4:0][7:0] fr;
      inputs++;
      if (op == OP_TICK) begin
        if (phase == PH_AWAIT) begin
          ignored++;
          return;
        end
        // A tick only counts down until the countdown reaches one or zero.
        if (countdown > 8'd1) begin
          countdown--;
          return;
        end
        countdown = 8'd0;
        if (phase == PH_MOVE) begin
          push_word(KIND_SERVO, angle, 8'd0, 1'b1);
          phase     = PH_SETTLE;
          countdown = cfg.settle_ticks;
        end else begin
          push_word(KIND_MEASURE, 8'd0, 8'd0, 1'b1);
          phase = PH_AWAIT;
        end
        return;
      end
      if (phase != PH_AWAIT) begin
        ignored++;
        return;
      end
      status  = echo && (dist_q4 <= {4'd0, cfg.range_max_cm, 4'd0});
      rounded = {1'b0, dist_q4} + 17'd8;
      dbyte   = (rounded[16:4] > 13'd255) ? 8'hFF : rounded[11:4];
      if (!status) dbyte = 8'hFF;
      fr[0] = FRAME_HEAD;
      fr[1] = angle;
      fr[2] = {7'd0, status};
      fr[3] = dbyte;
      fr[4] = fr[0] + fr[1] + fr[2] + fr[3];
      for (int i = 0; i < 5; i++) push_word(KIND_FRAME, 8'd0, fr[i], i == 4);
      step_angle();
      phase     = PH_MOVE;
      countdown = cfg.gap_ticks;
    endfunction

    function void take_output(logic [1:0] kind, logic [7:0] sa, logic [7:0] fb, logic is_last);
      out_word_t w;
      if (due_words.size() == 0) begin
        fault($sformatf("unexpected word kind %0d angle %0d byte %02h last %0b",
                        kind, sa, fb, is_last));
        return;
      end
      w = due_words.pop_front();
      words_seen++;
      if (w.kind !== kind || w.servo_angle !== sa || w.frame_byte !== fb ||
          w.is_last !== is_last) begin
        fault($sformatf("expected kind %0d angle %0d byte %02h last %0b, got %0d %0d %02h %0b",
                        w.kind, w.servo_angle, w.frame_byte, w.is_last, kind, sa, fb, is_last));
      end
      if (w.kind == KIND_SERVO) servo_count++;
      if (w.kind == KIND_MEASURE) measure_count++;
      if (w.kind == KIND_FRAME && w.is_last) frame_count++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = 5'd0;
  logic [31:0] pwdata = 32'd0;
  wire  [31:0] prdata;
  wire         pready;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [15:0] s_tdata = 16'd0;
  logic [1:0]  s_tuser = 2'd0;
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [15:0] m_tdata;
  wire  [1:0]  m_tuser;
  wire         m_tlast;

  sweep_tracker sb = new();

  int burst_left = 0;
  int settings = 0;
  int tries;
  int stall_mode = 0;
  int stall_left = 0;
  int beat = 0;

  sweep_radar_sequencer_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the design hangs; the expected run is far shorter than this.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Output side. A word is checked at the edge that accepts it, then the ready line
  // for the next cycle is chosen. The receiver runs in modes that each last a while:
  // always ready, coin toss, mostly stalled, and a fixed one-in-eight stall.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.take_output(m_tuser, m_tdata[7:0], m_tdata[15:8], m_tlast);
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    beat++;
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 1) != 0);
      2:       m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (beat % 8 != 0);
    endcase
  end

  // Register write: setup cycle, access cycle, then an idle cycle so that the next
  // transfer never assigns the bus lines twice in the same step.
  task bus_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task bus_read(logic [2:0] idx, output logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    val = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes every register with random junk above its width, pokes unused indexes 5 and 7,
  // and reads the map back against the mirror.
  task apply_settings(logic [7:0] amax, logic [6:0] st, logic [7:0] settle,
                      logic [7:0] gap, logic [7:0] range_cm);
    logic [31:0] got;
    bus_write(REG_ANGLE_MAX,    {24'($urandom), amax});
    bus_write(REG_ANGLE_STEP,   {25'($urandom), st});
    bus_write(REG_SETTLE_TICKS, {24'($urandom), settle});
    bus_write(REG_GAP_TICKS,    {24'($urandom), gap});
    bus_write(REG_RANGE_MAX_CM, {24'($urandom), range_cm});
    bus_write(REG_SPARE,     $urandom);
    bus_write(REG_SPARE_TOP, $urandom);
    for (int i = 0; i <= REG_RANGE_MAX_CM; i++) begin
      bus_read(3'(i), got);
      if (got !== sb.reg_value(3'(i))) begin
        sb.fault($sformatf("register %0d read %08h, expected %08h", i, got,
                           sb.reg_value(3'(i))));
      end
    end
    settings++;
  endtask

  // Stops the sender, lets every expected word drain, and then waits on so that a word
  // that produced nothing can clear the input stage.
  task settle_down();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Sends one input word. The sender works in bursts; between bursts it may drop
  // valid. Valid stays high across back-to-back words.
  task send_item(logic op, logic echo, logic [15:0] dist_q4);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {echo, op};
    s_tdata  <= dist_q4;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_input(op, echo, dist_q4);
    burst_left--;
  endtask

  // A complete sweep step: ticks until the sequencer waits for an echo, optionally a
  // stray tick during the wait, then the measurement result itself.
  task measure_cycle(logic echo, logic [15:0] dist_q4, logic with_noise);
    while (sb.phase != PH_AWAIT) send_item(OP_TICK, 1'($urandom), 16'($urandom));
    if (with_noise) send_item(OP_TICK, 1'($urandom), 16'($urandom));
    send_item(OP_RESULT, echo, dist_q4);
  endtask

  // Mostly well-formed traffic: ticks outside the wait, results during it, with a
  // share of stray words. Some distances sit on or just beside the range boundary.
  task random_item();
    logic        op;
    logic [15:0] dist_q4;
    logic [15:0] bound16;
    int          r;
    if ($urandom_range(0, 59) == 0) settle_down();
    r = $urandom_range(0, 99);
    if (sb.phase == PH_AWAIT) op = (r < 85) ? OP_RESULT : OP_TICK;
    else op = (r < 92) ? OP_TICK : OP_RESULT;
    bound16 = {4'd0, sb.cfg.range_max_cm, 4'd0};
    case ($urandom_range(0, 4))
      0:       dist_q4 = 16'($urandom);
      1:       dist_q4 = 16'($urandom_range(0, bound16));
      2:       dist_q4 = bound16 + 16'($urandom_range(0, 2)) - 16'd1;
      3:       dist_q4 = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      default: dist_q4 = 16'($urandom_range(0, 4095));
    endcase
    send_item(op, ($urandom_range(0, 3) != 0), dist_q4);
  endtask

  task random_items(int n);
    for (int i = 0; i < n; i++) random_item();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: a stray result in the move phase, a target exactly on the range
    // boundary, one just beyond it with a tick during the wait, and a failed echo.
    send_item(OP_RESULT, 1'b1, 16'd0);
    measure_cycle(1'b1, 16'd800, 1'b0);
    measure_cycle(1'b1, 16'd801, 1'b1);
    measure_cycle(1'b0, 16'd0, 1'b0);

    // Widest range, biggest legal step, zero waits; the largest distances.
    settle_down();
    apply_settings(8'd180, 7'd90, 8'd0, 8'd0, 8'd255);
    measure_cycle(1'b1, 16'd0, 1'b0);
    measure_cycle(1'b1, 16'd4080, 1'b0);
    measure_cycle(1'b1, 16'hFFFF, 1'b0);
    random_items(40);

    // Limit above the hard stop, a step beyond the normal range, zero range.
    settle_down();
    apply_settings(8'd255, 7'd127, 8'd3, 8'd2, 8'd0);
    measure_cycle(1'b1, 16'd0, 1'b0);
    random_items(40);

    // A zero limit pins the angle at zero.
    settle_down();
    apply_settings(8'd0, 7'd5, 8'd1, 8'd0, 8'd100);
    random_items(40);

    // A zero step leaves the angle where it is.
    settle_down();
    apply_settings(8'd37, 7'd0, 8'd2, 8'd1, 8'd20);
    random_items(40);

    // Run until the sweep is coming down from a high angle, then lower the limit
    // below the current angle: the angle must keep descending from there.
    settle_down();
    apply_settings(8'd180, 7'd50, 8'd1, 8'd1, 8'd50);
    tries = 0;
    while (!(sb.going_down && sb.angle > 8'd40) && tries < 400) begin
      random_item();
      tries++;
    end
    settle_down();
    apply_settings(8'd20, 7'd7, 8'd2, 8'd3, 8'd60);
    random_items(40);

    // Long waits and the smallest sweep.
    settle_down();
    apply_settings(8'd1, 7'd1, 8'd24, 8'd20, 8'd128);
    measure_cycle(1'b1, 16'($urandom_range(0, 4095)), 1'b0);
    measure_cycle(1'b1, 16'($urandom_range(0, 4095)), 1'b0);

    // Zero limit with zero step: the clamp and reversal still happen at the limit.
    settle_down();
    apply_settings(8'd0, 7'd0, 8'd0, 8'd0, 8'd255);
    random_items(20);

    for (int k = 0; k < 3; k++) begin
      settle_down();
      apply_settings(8'($urandom_range(1, 180)), 7'($urandom_range(1, 90)),
                     8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)), 8'($urandom));
      random_items(40);
    end

    settle_down();
    repeat (20) @(posedge clk);

    $display("Covered %0d input words (%0d ignored) under %0d register settings.",
             sb.inputs, sb.ignored, settings + 1);
    $display("Checked %0d output words: %0d servo commands, %0d measure requests, %0d frames.",
             sb.words_seen, sb.servo_count, sb.measure_count, sb.frame_count);
    if (sb.faults == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/srs_pkg.sv
hdl/srs_seq.sv
hdl/sweep_radar_sequencer_unit.sv
test/tb.sv
